@@ rtl/assert_macros.svh @@
// Assertion helper macros shared by the mass assignment RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge while reset is released.
`define CMA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cma assertion failed");
// Checked on every clock edge, reset included.
`define CMA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cma assertion failed");
`else
`define CMA_ASSERT(lbl, clk, rst_n, prop)
`define CMA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/cma_pkg.sv @@
// Types and constants for the mass assignment block.
// Used by the top level; has no dependencies.
`default_nettype none
package cma_pkg;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] ACT_DEPOSIT  = 2'd0;
    localparam logic [1:0] ACT_READ     = 2'd1;
    localparam logic [1:0] ACT_READ_CLR = 2'd2;
    localparam logic [1:0] ACT_SPARE    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GRID_SIZE    = 2'd0;
    localparam logic [1:0] CFG_SCALE        = 2'd1;
    localparam logic [1:0] CFG_FIELD_SELECT = 2'd2;
    localparam logic [1:0] CFG_ASSIGN       = 2'd3;

    // Field select codes: unit density or one velocity component.
    localparam logic [1:0] FSEL_UNIT = 2'd0;
    localparam logic [1:0] FSEL_VX   = 2'd1;
    localparam logic [1:0] FSEL_VY   = 2'd2;
    localparam logic [1:0] FSEL_VZ   = 2'd3;

    // Stream widths.
    localparam int IN_DATA_W  = 216;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GMUL,
        ST_GSPLIT,
        ST_GDIV,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_WRITE,
        ST_RMUL1,
        ST_RMUL2,
        ST_RCHK,
        ST_RREAD,
        ST_RDATA,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

@@ rtl/cma_mod.sv @@
// Bit-serial remainder unit: dividend modulo a small side length.
// Stand-alone; one dividend bit is folded in per cycle.
`default_nettype none
module cma_mod #(
    parameter int QW = 32,
    parameter int NW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [QW-1:0] i_div,
    input  wire logic [NW-1:0] i_n,
    output logic      [NW-1:0] o_rem,
    output logic               o_busy
);

    localparam int KW = $clog2(QW + 1);

    logic [QW-1:0] r_q;
    logic [NW-1:0] r_rem;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic [NW:0]   w_trial;
    logic [NW-1:0] w_next;

    // The running remainder stays below n, so one compare and subtract keeps it there.
    always_comb begin
        w_trial = {r_rem, r_q[QW-1]};
        if (w_trial >= {1'b0, i_n}) begin
            w_next = NW'(w_trial - {1'b0, i_n});
        end else begin
            w_next = NW'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == KW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_div;
            r_rem <= '0;
            r_cnt <= KW'(QW);
        end else if (r_busy) begin
            r_q   <= r_q << 1;
            r_rem <= w_next;
            r_cnt <= r_cnt - KW'(1);
        end
    end

    assign o_rem  = r_rem;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

@@ rtl/cic_mass_assignment_top.sv @@
// Top level of the cloud-in-cell / nearest-grid-point mass assignment block.
// Depends on cma_pkg, cma_mod and assert_macros.svh.
//
// Usage: requests enter on the s_axis channel, one result per request leaves on
// m_axis. A deposit request scales the position to grid units, finds the home
// cell per axis with a serial remainder unit, then updates one cell (nearest
// grid point) or eight cells (cloud in cell) of the grid memory by
// read-modify-write with a saturating add. Read requests return one cell, and
// read-and-clear requests also zero it. Configuration writes go through the
// plain i_cfg port and are taken at any edge with i_cfg_we high.
// Sequence: each axis takes one multiply, one split and the bit-serial
// remainder, and each updated cell passes through ST_M1, ST_M2, ST_M3 and
// ST_WRITE on the one shared 33x33 multiplier and the single memory write port.
// One request is in work at a time; s_axis_tready is high only while the
// sequencer is idle.
// Reset: the grid memory is swept to zero, one cell per cycle, over all GRID_MAX^3
// cells (262144 by default); no request is taken until the sweep ends.
// Stall: the result waits in an output register; the next request can be
// taken while it waits, and its own result is held back until the first leaves.
`default_nettype none
`include "assert_macros.svh"
module cic_mass_assignment_top
    import cma_pkg::*;
#(
    parameter int GRID_MAX  = 64,
    parameter int ACC_BITS  = 48,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata from bit 0 up: pos_x[31:0], pos_y, pos_z, vel_x, vel_y, vel_z,
    // cell_index[17:0], zero fill to 216 bits.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action[1:0].
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    // Result channel.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: cell_value[47:0].
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: saturated.
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_addr,
    input  wire logic [31:0]           i_cfg_wdata
);

    localparam int CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(GRID_MAX + 1);
    localparam int CW    = $clog2(GRID_MAX);
    localparam int QW    = 64 - 2 * FRAC_BITS;
    localparam int XW    = (AW > 18) ? AW : 18;
    localparam logic [FRAC_BITS:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    t_state r_state, n_state;

    // Configuration.
    logic [6:0]  r_grid_size;
    logic [31:0] r_scale;
    logic [1:0]  r_field_sel;
    logic        r_assign;

    // Request capture.
    logic [1:0]         r_action;
    logic [31:0]        r_pos [3];
    logic signed [32:0] r_w;
    logic [17:0]        r_idx;

    // Sequencer and datapath.
    logic [AW-1:0]          r_clr_cnt;
    logic [1:0]             r_axis;
    logic [FRAC_BITS-1:0]   r_frac [3];
    logic [CW-1:0]          r_cell [3];
    logic [CW-1:0]          r_cn [3];
    logic [2:0]             r_corner;
    logic signed [65:0]     r_prod;
    logic [2*NW-1:0]        r_a1;
    logic [AW-1:0]          r_addr;
    logic [ACC_BITS-1:0]    r_rd;
    logic                   r_inr;
    logic                   r_sat;
    logic [OUT_DATA_W-1:0]  r_res_val;
    logic [OUT_DATA_W-1:0]  r_out_val;
    logic                   r_out_sat;
    logic                   r_out_valid;

    logic [ACC_BITS-1:0] r_mem [CELLS];

    logic                  w_accept;
    logic                  w_load;
    logic [NW-1:0]         w_n;
    logic                  w_mul_en;
    logic signed [32:0]    w_mul_a, w_mul_b;
    logic                  w_mod_start;
    logic [NW-1:0]         w_rem;
    logic                  w_mod_busy;
    logic [FRAC_BITS:0]    w_wx, w_wy, w_wz;
    logic [CW-1:0]         w_ix, w_iy, w_iz;
    logic [2*NW-1:0]       w_n2, w_ix2, w_iy2;
    logic [3*NW-1:0]       w_n3, w_a13, w_iz3, w_addr_full;
    logic [NW:0]           w_rem_inc;
    logic signed [32:0]    w_t;
    logic signed [ACC_BITS:0] w_old_e, w_t_e, w_sum;
    logic                  w_ovf;
    logic signed [63:0]    w_rd64;
    logic [XW-1:0]         w_idx_ext;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [ACC_BITS-1:0]   w_wdata;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);

    // Side length in use, clamped to the supported range.
    always_comb begin
        if (r_grid_size < 7'd2) begin
            w_n = NW'(2);
        end else if (32'(r_grid_size) > 32'(GRID_MAX)) begin
            w_n = NW'(GRID_MAX);
        end else begin
            w_n = NW'(r_grid_size);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= 7'd64;
            r_scale     <= 32'd65536;
            r_field_sel <= FSEL_UNIT;
            r_assign    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRID_SIZE:    r_grid_size <= i_cfg_wdata[6:0];
                CFG_SCALE:        r_scale     <= i_cfg_wdata;
                CFG_FIELD_SELECT: r_field_sel <= i_cfg_wdata[1:0];
                CFG_ASSIGN:       r_assign    <= i_cfg_wdata[0];
                default:          r_grid_size <= r_grid_size;
            endcase
        end
    end

    // Corner weights: 1 - d on the home side, d on the +1 side. Nearest grid
    // point uses 1.0 on every axis, which leaves the weight unchanged.
    always_comb begin
        if (r_assign) begin
            w_wx = r_corner[2] ? {1'b0, r_frac[0]} : FX_ONE - {1'b0, r_frac[0]};
            w_wy = r_corner[1] ? {1'b0, r_frac[1]} : FX_ONE - {1'b0, r_frac[1]};
            w_wz = r_corner[0] ? {1'b0, r_frac[2]} : FX_ONE - {1'b0, r_frac[2]};
        end else begin
            w_wx = FX_ONE;
            w_wy = FX_ONE;
            w_wz = FX_ONE;
        end
        w_ix = r_corner[2] ? r_cn[0] : r_cell[0];
        w_iy = r_corner[1] ? r_cn[1] : r_cell[1];
        w_iz = r_corner[0] ? r_cn[2] : r_cell[2];
    end

    // Flat cell address z + n*(y + n*x); n*x + y is registered in ST_M1, the full address in ST_M2.
    assign w_n2        = (2*NW)'(w_n);
    assign w_ix2       = (2*NW)'(w_ix);
    assign w_iy2       = (2*NW)'(w_iy);
    assign w_n3        = (3*NW)'(w_n);
    assign w_a13       = (3*NW)'(r_a1);
    assign w_iz3       = (3*NW)'(w_iz);
    assign w_addr_full = w_n3 * w_a13 + w_iz3;

    assign w_rem_inc = {1'b0, w_rem} + (NW+1)'(1);

    // Shared multiplier operand select.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_GMUL: begin
                w_mul_a = {1'b0, r_pos[r_axis]};
                w_mul_b = {1'b0, r_scale};
            end
            ST_M1: begin
                w_mul_a = r_w;
                w_mul_b = 33'(w_wx);
            end
            ST_M2: begin
                w_mul_a = r_prod[FRAC_BITS+32:FRAC_BITS];
                w_mul_b = 33'(w_wy);
            end
            ST_M3: begin
                w_mul_a = r_prod[FRAC_BITS+32:FRAC_BITS];
                w_mul_b = 33'(w_wz);
            end
            ST_RMUL1: begin
                w_mul_a = 33'(w_n);
                w_mul_b = 33'(w_n);
            end
            ST_RMUL2: begin
                w_mul_a = r_prod[32:0];
                w_mul_b = 33'(w_n);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Saturating accumulate of the truncated corner contribution.
    assign w_t     = r_prod[FRAC_BITS+32:FRAC_BITS];
    assign w_old_e = (ACC_BITS+1)'($signed(r_rd));
    assign w_t_e   = (ACC_BITS+1)'(w_t);
    assign w_sum   = w_old_e + w_t_e;
    assign w_ovf   = w_sum[ACC_BITS] != w_sum[ACC_BITS-1];
    assign w_rd64  = 64'($signed(r_rd));
    assign w_idx_ext = XW'(r_idx);

    // Next state and strobes.
    always_comb begin
        n_state     = r_state;
        w_mul_en    = 1'b0;
        w_mod_start = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_cnt;
                if (r_clr_cnt == AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == ACT_DEPOSIT) begin
                        n_state = ST_GMUL;
                    end else if (s_axis_tuser == ACT_READ || s_axis_tuser == ACT_READ_CLR) begin
                        n_state = ST_RMUL1;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_GMUL: begin
                w_mul_en = 1'b1;
                n_state  = ST_GSPLIT;
            end
            ST_GSPLIT: begin
                w_mod_start = 1'b1;
                n_state     = ST_GDIV;
            end
            ST_GDIV: begin
                if (!w_mod_busy) begin
                    n_state = (r_axis == 2'd2) ? ST_M1 : ST_GMUL;
                end
            end
            ST_M1: begin
                w_mul_en = 1'b1;
                n_state  = ST_M2;
            end
            ST_M2: begin
                w_mul_en = 1'b1;
                n_state  = ST_M3;
            end
            ST_M3: begin
                w_mul_en = 1'b1;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                w_we    = 1'b1;
                w_wdata = w_ovf ? (w_sum[ACC_BITS] ? ACC_MIN : ACC_MAX)
                                : w_sum[ACC_BITS-1:0];
                if (!r_assign || r_corner == 3'd7) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_M1;
                end
            end
            ST_RMUL1: begin
                w_mul_en = 1'b1;
                n_state  = ST_RMUL2;
            end
            ST_RMUL2: begin
                w_mul_en = 1'b1;
                n_state  = ST_RCHK;
            end
            ST_RCHK: begin
                n_state = ST_RREAD;
            end
            ST_RREAD: begin
                n_state = ST_RDATA;
            end
            ST_RDATA: begin
                w_we    = r_inr && (r_action == ACT_READ_CLR);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= 66'(w_mul_a) * 66'(w_mul_b);
        end
        if (w_load) begin
            r_out_val <= r_res_val;
            r_out_sat <= r_sat;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_action  <= s_axis_tuser;
                    r_pos[0]  <= s_axis_tdata[31:0];
                    r_pos[1]  <= s_axis_tdata[63:32];
                    r_pos[2]  <= s_axis_tdata[95:64];
                    r_idx     <= s_axis_tdata[209:192];
                    r_axis    <= 2'd0;
                    r_corner  <= 3'd0;
                    r_sat     <= 1'b0;
                    r_res_val <= '0;
                    case (r_field_sel)
                        FSEL_VX: r_w <= 33'($signed(s_axis_tdata[127:96]));
                        FSEL_VY: r_w <= 33'($signed(s_axis_tdata[159:128]));
                        FSEL_VZ: r_w <= 33'($signed(s_axis_tdata[191:160]));
                        default: r_w <= 33'(FX_ONE);
                    endcase
                end
            end
            ST_GSPLIT: begin
                r_frac[r_axis] <= r_prod[2*FRAC_BITS-1:FRAC_BITS];
            end
            ST_GDIV: begin
                if (!w_mod_busy) begin
                    r_cell[r_axis] <= CW'(w_rem);
                    r_cn[r_axis]   <= (w_rem_inc == {1'b0, w_n}) ? '0 : CW'(w_rem_inc);
                    r_axis         <= r_axis + 2'd1;
                end
            end
            ST_M1: begin
                r_a1 <= w_n2 * w_ix2 + w_iy2;
            end
            ST_M2: begin
                r_addr <= AW'(w_addr_full);
            end
            ST_WRITE: begin
                r_sat    <= r_sat | w_ovf;
                r_corner <= r_corner + 3'd1;
            end
            ST_RCHK: begin
                r_inr  <= 66'(r_idx) < $unsigned(r_prod);
                r_addr <= w_idx_ext[AW-1:0];
            end
            ST_RDATA: begin
                r_res_val <= r_inr ? w_rd64[OUT_DATA_W-1:0] : '0;
            end
            default: begin
                r_inr <= r_inr;
            end
        endcase
    end

    // Grid memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    cma_mod #(
        .QW (QW),
        .NW (NW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_div   (r_prod[63:2*FRAC_BITS]),
        .i_n     (w_n),
        .o_rem   (w_rem),
        .o_busy  (w_mod_busy)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = r_out_sat;

    // Memory writes only come from the sweep, a corner update or a clear.
    `CMA_ASSERT_ALWAYS(a_wr_src, i_clk, w_we |-> (r_state == ST_CLEAR || r_state == ST_WRITE || r_state == ST_RDATA))
    // A deposit request starts with the position multiply.
    `CMA_ASSERT(a_dep_start, i_clk, i_rst_n, (w_accept && s_axis_tuser == ACT_DEPOSIT) |=> (r_state == ST_GMUL))
    // Nearest grid point updates a single cell.
    `CMA_ASSERT(a_ngp_one, i_clk, i_rst_n, (r_state == ST_WRITE && !r_assign) |=> (r_state == ST_FIN))
    // The remainder unit only runs while the sequencer waits on it.
    `CMA_ASSERT(a_mod_busy, i_clk, i_rst_n, w_mod_busy |-> (r_state == ST_GDIV))

endmodule
`default_nettype wire
